>>> hw/rtl/caob_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package caob_pkg;

    // Field widths
    localparam int PIX_W      = 32;
    localparam int COV_W      = 8;
    localparam int CH_W       = 8;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    // Register map
    localparam logic [APB_ADDR_W-1:0] ADDR_TEXT_COLOR = 2'd0;
    localparam logic [PIX_W-1:0]      TEXT_COLOR_RESET = 32'hFFFF_FFFF;

    // Channel limits
    localparam logic [CH_W-1:0] CH_MAX  = 8'hFF;
    localparam logic [CH_W-1:0] CH_ZERO = 8'h00;

    // Reciprocals of 255: ceil(2^24/255) and ceil(2^32/255).
    // Exact floor division for products of two bytes and of three bytes.
    localparam logic [16:0] RECIP_255_Q24 = 17'd65794;
    localparam logic [24:0] RECIP_255_Q32 = 25'd16843010;

endpackage

`default_nettype wire

>>> hw/rtl/caob_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Pixel input channel: coverage plus destination pixel
interface caob_pix_in_if
    import caob_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [COV_W-1:0] coverage;
    logic [PIX_W-1:0] dst_pixel;

    modport source (output valid, output coverage, output dst_pixel, input ready);
    modport sink   (input valid, input coverage, input dst_pixel, output ready);
endinterface

// Pixel output channel: blended pixel
interface caob_pix_out_if
    import caob_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;

    modport source (output valid, output out_pixel, input ready);
    modport sink   (input valid, input out_pixel, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/coverage_alpha_over_blend.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one pixel per cycle unless pix_out stalls; the per-channel divide
// by output alpha is split over four stages of two restoring steps each, which
// sets the depth. A stall on pix_out freezes every stage at once; nothing is
// dropped or repeated.
// Reset clears all stage valid bits and sets text_color to opaque white.
module coverage_alpha_over_blend
    import caob_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    caob_pix_in_if.sink                pix_in,
    caob_pix_out_if.source             pix_out
);

    localparam int FRONT_STAGES = 6;
    localparam int DIV_STAGES   = 4;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES;

    typedef struct packed {
        logic             pass;
        logic             opaque;
        logic [PIX_W-1:0] dst;
        logic [23:0]      rgb;
    } side_t;

    // Configuration register
    logic [PIX_W-1:0] text_color_reg;

    // Pipeline control
    logic                   adv;
    logic [PIPE_STAGES-1:0] pipe_valid_reg;
    logic [PIPE_STAGES-1:0] pipe_valid_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    // Stage 1: alpha times coverage
    logic [15:0]      s1_prod_next, s1_prod_reg;
    logic [PIX_W-1:0] s1_dst_reg, s1_color_reg;

    // Stage 2: effective source alpha
    logic [32:0]      s2_sa_wide;
    logic [7:0]       s2_sa_next, s2_sa_reg;
    side_t            s2_side_next, s2_side_reg;

    // Stage 3: byte products
    logic [7:0]       s3_inv_next, s3_inv_reg;
    logic [15:0]      s3_dainv_next, s3_dainv_reg;
    logic [2:0][15:0] s3_dcda_next, s3_dcda_reg;
    logic [2:0][15:0] s3_scsa_next, s3_scsa_reg;
    logic [7:0]       s3_sa_reg;
    side_t            s3_side_reg;

    // Stage 4: output alpha, three-byte products
    logic [32:0]      s4_oa_wide;
    logic [8:0]       s4_oa_sum;
    logic [7:0]       s4_oa_next, s4_oa_reg;
    logic [2:0][23:0] s4_dcdainv_next, s4_dcdainv_reg;
    logic [2:0][15:0] s4_scsa_reg;
    side_t            s4_side_reg;

    // Stage 5: destination term divided by 255
    logic [2:0][15:0] s5_t_next, s5_t_reg;
    logic [2:0][15:0] s5_scsa_reg;
    logic [7:0]       s5_oa_reg;
    side_t            s5_side_reg;

    // Stage 6: channel numerators and overflow flags
    logic [2:0][16:0] s6_num_next, s6_num_reg;
    logic [2:0]       s6_sat_next, s6_sat_reg;
    logic [7:0]       s6_oa_reg;
    side_t            s6_side_reg;

    // Divider stages
    logic [DIV_STAGES-1:0][2:0][16:0] dv_rem_next, dv_rem_reg;
    logic [DIV_STAGES-1:0][2:0][7:0]  dv_q_next, dv_q_reg;
    logic [DIV_STAGES-1:0][2:0]       dv_sat_next, dv_sat_reg;
    logic [DIV_STAGES-1:0][7:0]       dv_oa_next, dv_oa_reg;
    side_t [DIV_STAGES-1:0]           dv_side_next, dv_side_reg;

    // Output register
    logic [PIX_W-1:0] out_pixel_next, out_pixel_reg;

    // APB: write on access phase, read back the register
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_TEXT_COLOR)
        begin
            prdata = text_color_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= TEXT_COLOR_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_TEXT_COLOR)
        begin
            text_color_reg <= pwdata;
        end
    end

    // Advance the whole pipe unless the output register is full and held
    assign adv          = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = adv;

    assign pipe_valid_next = {pipe_valid_reg[PIPE_STAGES-2:0], pix_in.valid};
    assign out_valid_next  = pipe_valid_reg[PIPE_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Stage 1
    assign s1_prod_next = {8'd0, text_color_reg[31:24]} * {8'd0, pix_in.coverage};

    // Stage 2: floor divide by 255 through the reciprocal, flag trivial cases
    always_comb
    begin
        s2_sa_wide          = {17'd0, s1_prod_reg} * {16'd0, RECIP_255_Q24};
        s2_sa_next          = s2_sa_wide[31:24];
        s2_side_next.pass   = (s2_sa_next == CH_ZERO);
        s2_side_next.opaque = (s2_sa_next == CH_MAX);
        s2_side_next.dst    = s1_dst_reg;
        s2_side_next.rgb    = s1_color_reg[23:0];
    end

    // Stage 3: byte products per channel
    always_comb
    begin
        s3_inv_next   = CH_MAX - s2_sa_reg;
        s3_dainv_next = {8'd0, s2_side_reg.dst[31:24]} * {8'd0, s3_inv_next};
        for (int k = 0; k < 3; k++)
        begin
            s3_dcda_next[k] = {8'd0, s2_side_reg.dst[8*k +: 8]} * {8'd0, s2_side_reg.dst[31:24]};
            s3_scsa_next[k] = {8'd0, s2_side_reg.rgb[8*k +: 8]} * {8'd0, s2_sa_reg};
        end
    end

    // Stage 4: output alpha and destination products
    always_comb
    begin
        s4_oa_wide = {17'd0, s3_dainv_reg} * {16'd0, RECIP_255_Q24};
        s4_oa_sum  = {1'b0, s3_sa_reg} + {1'b0, s4_oa_wide[31:24]};
        s4_oa_next = s4_oa_sum[7:0];
        for (int k = 0; k < 3; k++)
        begin
            s4_dcdainv_next[k] = {8'd0, s3_dcda_reg[k]} * {16'd0, s3_inv_reg};
        end
    end

    // Stage 5: destination term floor divided by 255
    always_comb
    begin
        logic [48:0] t_wide;
        for (int k = 0; k < 3; k++)
        begin
            t_wide       = {25'd0, s4_dcdainv_reg[k]} * {24'd0, RECIP_255_Q32};
            s5_t_next[k] = t_wide[47:32];
        end
    end

    // Stage 6: numerator, and saturate when the quotient would pass 255
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s6_num_next[k] = {1'b0, s5_scsa_reg[k]} + {1'b0, s5_t_reg[k]};
            s6_sat_next[k] = (s6_num_next[k] >= {1'b0, s5_oa_reg, 8'd0});
        end
    end

    // Divider: two restoring steps per stage, quotient msb first
    always_comb
    begin
        logic [16:0] r;
        logic [7:0]  q;
        logic [16:0] d;
        logic [2:0]  bi;
        logic [7:0]  oa;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (j == 0)
            begin
                oa              = s6_oa_reg;
                dv_sat_next[j]  = s6_sat_reg;
                dv_side_next[j] = s6_side_reg;
            end
            else
            begin
                oa              = dv_oa_reg[j-1];
                dv_sat_next[j]  = dv_sat_reg[j-1];
                dv_side_next[j] = dv_side_reg[j-1];
            end
            dv_oa_next[j] = oa;
            for (int k = 0; k < 3; k++)
            begin
                if (j == 0)
                begin
                    r = s6_num_reg[k];
                    q = '0;
                end
                else
                begin
                    r = dv_rem_reg[j-1][k];
                    q = dv_q_reg[j-1][k];
                end
                for (int st = 0; st < 2; st++)
                begin
                    bi = 3'(7 - 2 * j - st);
                    d  = {9'd0, oa} << bi;
                    if (r >= d)
                    begin
                        r     = r - d;
                        q[bi] = 1'b1;
                    end
                end
                dv_rem_next[j][k] = r;
                dv_q_next[j][k]   = q;
            end
        end
    end

    // Output assembly
    always_comb
    begin
        side_t sd;
        sd = dv_side_reg[DIV_STAGES-1];
        priority if (sd.pass)
        begin
            out_pixel_next = sd.dst;
        end
        else if (sd.opaque)
        begin
            out_pixel_next = {CH_MAX, sd.rgb};
        end
        else if (dv_oa_reg[DIV_STAGES-1] == CH_ZERO)
        begin
            out_pixel_next = '0;
        end
        else
        begin
            out_pixel_next[31:24] = dv_oa_reg[DIV_STAGES-1];
            for (int k = 0; k < 3; k++)
            begin
                out_pixel_next[8*k +: 8] = dv_sat_reg[DIV_STAGES-1][k] ? CH_MAX
                                                                       : dv_q_reg[DIV_STAGES-1][k];
            end
        end
    end

    // Payload registers: advance together with the valid bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_prod_reg     <= s1_prod_next;
            s1_dst_reg      <= pix_in.dst_pixel;
            s1_color_reg    <= text_color_reg;

            s2_sa_reg       <= s2_sa_next;
            s2_side_reg     <= s2_side_next;

            s3_inv_reg      <= s3_inv_next;
            s3_dainv_reg    <= s3_dainv_next;
            s3_dcda_reg     <= s3_dcda_next;
            s3_scsa_reg     <= s3_scsa_next;
            s3_sa_reg       <= s2_sa_reg;
            s3_side_reg     <= s2_side_reg;

            s4_oa_reg       <= s4_oa_next;
            s4_dcdainv_reg  <= s4_dcdainv_next;
            s4_scsa_reg     <= s3_scsa_reg;
            s4_side_reg     <= s3_side_reg;

            s5_t_reg        <= s5_t_next;
            s5_scsa_reg     <= s4_scsa_reg;
            s5_oa_reg       <= s4_oa_reg;
            s5_side_reg     <= s4_side_reg;

            s6_num_reg      <= s6_num_next;
            s6_sat_reg      <= s6_sat_next;
            s6_oa_reg       <= s5_oa_reg;
            s6_side_reg     <= s5_side_reg;

            dv_rem_reg      <= dv_rem_next;
            dv_q_reg        <= dv_q_next;
            dv_sat_reg      <= dv_sat_next;
            dv_oa_reg       <= dv_oa_next;
            dv_side_reg     <= dv_side_next;

            out_pixel_reg   <= out_pixel_next;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_pixel = out_pixel_reg;

    // A stall freezes every valid bit
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(pipe_valid_reg))
        else $error("pipeline moved during a stall");

    // An accepted input shows up as a valid first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        adv && pix_in.valid |=> pipe_valid_reg[0])
        else $error("accepted pixel lost at pipe entry");

    // Blending path never divides by a zero output alpha
    a_oa_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg[FRONT_STAGES-1] && !s6_side_reg.pass && !s6_side_reg.opaque
            |-> s6_oa_reg != CH_ZERO)
        else $error("zero output alpha on blend path");

    // Opaque source yields an opaque result
    a_opaque_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv && pipe_valid_reg[PIPE_STAGES-1] && dv_side_reg[DIV_STAGES-1].opaque
            |=> out_pixel_reg[31:24] == CH_MAX)
        else $error("opaque source gave non-opaque result");

endmodule

`default_nettype wire

>>> tb/coverage_alpha_over_blend_tb.sv
`timescale 1ns / 1ps

module coverage_alpha_over_blend_tb
    import caob_pkg::*;
();

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 12;
    localparam int PIPE_DEPTH    = 11;
    localparam int SETTLE_CYCLES = 2 * PIPE_DEPTH;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 18;
    localparam int BLEND_PHASES  = 8;
    localparam int PHASE_PIXELS  = 68;
    localparam int STEADY_PHASE  = 3;

    // Expected blended pixels, predicted from the accepted pixel transfers
    class blend_scoreboard;
        logic [PIX_W-1:0] text_color;
        logic [PIX_W-1:0] expected_pixels[$];
        int               mismatches;

        function new();
            text_color = TEXT_COLOR_RESET;
            mismatches = 0;
        endfunction

        function void set_color(logic [PIX_W-1:0] value);
            text_color = value;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Porter-Duff over with coverage-weighted source alpha, floored divides
        function logic [PIX_W-1:0] blend_over(logic [PIX_W-1:0] src, logic [COV_W-1:0] cov,
                                              logic [PIX_W-1:0] dst);
            int unsigned src_a;
            int unsigned cov_u;
            int unsigned sa;
            int unsigned da;
            int unsigned inv;
            int unsigned oa;
            int unsigned sc;
            int unsigned dc;
            int unsigned ch;
            int unsigned sh;
            logic [PIX_W-1:0] px;
            src_a = {24'd0, src[31:24]};
            cov_u = {24'd0, cov};
            sa    = (src_a * cov_u) / 255;
            da    = {24'd0, dst[31:24]};
            if (sa == 0)
                return dst;
            if (sa == 255)
                return {CH_MAX, src[23:0]};
            inv = 255 - sa;
            oa  = sa + (da * inv) / 255;
            if (oa == 0)
                return '0;
            px = '0;
            px[31:24] = oa[7:0];
            for (int k = 0; k < 3; k++)
            begin
                sh = 16 - 8 * k;
                sc = (src >> sh) & 32'hFF;
                dc = (dst >> sh) & 32'hFF;
                ch = (sc * sa + (dc * da * inv) / 255) / oa;
                // saturate so a channel never spills into its neighbor
                if (ch > 255)
                    ch = 255;
                px = px | (ch << sh);
            end
            return px;
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            mismatches++;
        endtask

        task note_pixel(logic [COV_W-1:0] cov, logic [PIX_W-1:0] dst);
            expected_pixels.push_back(blend_over(text_color, cov, dst));
        endtask

        task check_pixel(logic [PIX_W-1:0] got);
            logic [PIX_W-1:0] want;
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected out_pixel %08h", got));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("out_pixel got %08h, want %08h", got, want));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    bit                    steady;
    int                    cycle_count;
    blend_scoreboard       board;

    caob_pix_in_if  pix_in_bus();
    caob_pix_out_if pix_out_bus();

    coverage_alpha_over_blend dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (pix_in_bus),
        .pix_out (pix_out_bus)
    );

    // Drive every input to a known value before the first edge
    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = ADDR_TEXT_COLOR;
        pwdata                = '0;
        pix_in_bus.valid      = 1'b0;
        pix_in_bus.coverage   = '0;
        pix_in_bus.dst_pixel  = '0;
        pix_out_bus.ready     = 1'b0;
        steady                = 1'b0;
        cycle_count           = 0;
        board                 = new();
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Stall the result side at random, except during the steady stretch
    always @(negedge clk)
    begin
        pix_out_bus.ready = steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Note accepted pixels first, then check results, all on the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_in_bus.valid && pix_in_bus.ready)
                board.note_pixel(pix_in_bus.coverage, pix_in_bus.dst_pixel);
            if (pix_out_bus.valid && pix_out_bus.ready)
                board.check_pixel(pix_out_bus.out_pixel);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Write text_color through an APB setup phase and access phase
    task write_color(input logic [PIX_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_TEXT_COLOR;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_color(value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Read text_color back and compare
    task read_color_check(input logic [PIX_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_TEXT_COLOR;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== want)
            board.report_mismatch($sformatf("text_color read %08h, want %08h", got, want));
    endtask

    // Offer one pixel, idling at random first; hold until the transfer
    task send_pixel(input logic [COV_W-1:0] cov, input logic [PIX_W-1:0] dst);
        bit taken;
        if (!steady)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                pix_in_bus.valid     = 1'b0;
                pix_in_bus.coverage  = 8'($urandom_range(255));
                pix_in_bus.dst_pixel = $urandom;
                @(negedge clk);
            end
        end
        pix_in_bus.valid     = 1'b1;
        pix_in_bus.coverage  = cov;
        pix_in_bus.dst_pixel = dst;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = pix_in_bus.ready;
            if (!taken)
                @(negedge clk);
        end
        @(negedge clk);
    endtask

    // Drop valid and hold off until every blended pixel has come back
    task wait_drain();
        pix_in_bus.valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task set_color_checked(input logic [PIX_W-1:0] value);
        wait_drain();
        write_color(value);
        read_color_check(value);
    endtask

    // Favor the alpha and coverage corners: none, full, and near them
    function logic [COV_W-1:0] pick_coverage();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (r < 30)
            return 8'hFF;
        if (r < 40)
            return 8'($urandom_range(1, 3));
        if (r < 45)
            return 8'($urandom_range(252, 254));
        return 8'($urandom_range(255));
    endfunction

    function logic [PIX_W-1:0] pick_dst();
        logic [PIX_W-1:0] px;
        int r;
        px = $urandom;
        r  = $urandom_range(99);
        if (r < 15)
            px[31:24] = 8'h00;
        else if (r < 30)
            px[31:24] = 8'hFF;
        else if (r < 40)
            px[31:24] = 8'($urandom_range(1, 3));
        if ($urandom_range(99) < 10)
            px[23:0] = 24'hFFFFFF;
        return px;
    endfunction

    function logic [PIX_W-1:0] pick_color();
        logic [PIX_W-1:0] c;
        int r;
        c = $urandom;
        r = $urandom_range(99);
        if (r < 15)
            c[31:24] = 8'hFF;
        else if (r < 25)
            c[31:24] = 8'($urandom_range(1, 3));
        else if (r < 30)
            c[31:24] = 8'h00;
        return c;
    endfunction

    // Main sequence
    initial
    begin
        logic [PIX_W-1:0] color;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset color is opaque white
        read_color_check(TEXT_COLOR_RESET);
        send_pixel(8'h00, 32'hFFFF_FFFF);
        send_pixel(8'h00, 32'h0000_0000);
        send_pixel(8'hFF, 32'h1234_5678);
        send_pixel(8'h01, 32'h01FF_FFFF);
        send_pixel(8'h01, 32'h0000_0000);
        send_pixel(8'h80, 32'h8080_8080);
        send_pixel(8'hFE, 32'hFF00_0000);

        // Half-transparent source: weighted alpha of one and of zero
        set_color_checked(32'h8012_3456);
        send_pixel(8'hFF, 32'hFFFF_FFFF);
        send_pixel(8'h02, 32'h01FF_FFFF);
        send_pixel(8'h01, 32'hFFAB_CDEF);
        send_pixel(8'hC8, 32'h00AB_CDEF);
        send_pixel(8'hFF, 32'h01FF_FFFF);

        // Fully transparent source passes everything through
        set_color_checked(32'h00FF_FFFF);
        send_pixel(8'hFF, 32'hDEAD_BEEF);

        // Opaque black
        set_color_checked(32'hFF00_0000);
        send_pixel(8'hFF, 32'hFFFF_FFFF);
        send_pixel(8'h64, 32'hFF00_FF00);
        send_pixel(8'h03, 32'h01FF_FFFF);

        // Source alpha of one: channel saturation
        set_color_checked(32'h01FF_FFFF);
        send_pixel(8'hFF, 32'h01FF_FFFF);
        send_pixel(8'hFE, 32'h7F12_3456);

        set_color_checked(32'h0000_0000);
        send_pixel(8'hFF, 32'h0000_0000);

        // Random phases, each under its own text color
        for (int p = 0; p < BLEND_PHASES; p++)
        begin
            case (p)
                0:       color = 32'hFFFF_FFFF;
                1:       color = 32'h0000_0000;
                2:       color = {8'h01, 24'($urandom)};
                default: color = pick_color();
            endcase
            set_color_checked(color);
            steady = (p == STEADY_PHASE);
            for (int i = 0; i < PHASE_PIXELS; i++)
                send_pixel(pick_coverage(), pick_dst());
            steady = 1'b0;
        end

        wait_drain();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
